[hdl/lcab_pkg.sv]
`timescale 1ns / 1ps
// Shared codes and field widths for the binary-lifting ancestor engine.
// Used by lca_binary_lifting; no dependencies.
package lcab_pkg;

    localparam int ID_W    = 7;  // node fields on the ports
    localparam int DEPTH_W = 7;  // node depth field
    localparam int REQ_W   = 2;

    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BUILD = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

endpackage

[hdl/lcab_ram.sv]
`timescale 1ns / 1ps
// Simple dual-read, single-write synchronous RAM with registered read data.
// Used by lca_binary_lifting for the jump table and the depth store.
module lcab_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr_a,
    output logic [W-1:0]  rdata_a,
    input  logic [AW-1:0] raddr_b,
    output logic [W-1:0]  rdata_b
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_a_reg;
    logic [W-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

[hdl/lca_binary_lifting.sv]
`timescale 1ns / 1ps
// Lowest common ancestor engine, binary lifting over a 2^k-ancestor table.
// Input channel s_*: one word per request. Load (s_req_type 0) writes a node's
// parent (or root flag) and depth; build (1) fills table levels 1..LOG_LEVELS-1
// from level 0; query (2) returns the lowest common ancestor of s_query_u and
// s_query_v on the m_* channel. Code 3 is dropped. Only queries give a result.
// Steps (L = LOG_LEVELS, N = MAX_NODES, all memory reads are registered):
//   load  : written on the accept edge.
//   build : (L-1)*N table entries; each entry needs its level-(k-1) word
//           and then, if valid, the word of that ancestor.
//   query : depth read, lift of up to L levels with a table read per set bit,
//           L descent steps of a read and a write-back each, parent read.
// One request is worked on at a time; s_ready is high only while idle. The
// result sits in an output register, so a new request is taken while a result
// waits for m_ready. A query result that finds the output register still full
// holds the engine until the receiver takes the earlier word.
// Reset clears the control state and the output valid. Table and depth
// memories are not cleared: a query or build touching an unloaded node gives
// an unspecified answer.
module lca_binary_lifting #(
    parameter int MAX_NODES  = 128,
    parameter int LOG_LEVELS = 7
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lcab_pkg::REQ_W-1:0]    s_req_type,
    input  logic [lcab_pkg::ID_W-1:0]     s_node_id,
    input  logic [lcab_pkg::ID_W-1:0]     s_parent_id,
    input  logic                          s_is_root,
    input  logic [lcab_pkg::DEPTH_W-1:0]  s_node_depth,
    input  logic [lcab_pkg::ID_W-1:0]     s_query_u,
    input  logic [lcab_pkg::ID_W-1:0]     s_query_v,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lcab_pkg::ID_W-1:0]     m_ancestor
);

    localparam int NW   = $clog2(MAX_NODES);
    localparam int EW   = NW + 1;
    localparam int JD   = LOG_LEVELS * MAX_NODES;
    localparam int JAW  = $clog2(JD);
    localparam int KW   = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
    localparam int NIDS = 1 << lcab_pkg::ID_W;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DEPTH   = 4'd1;
    localparam logic [3:0] ST_LIFT_RD = 4'd2;
    localparam logic [3:0] ST_LIFT_WB = 4'd3;
    localparam logic [3:0] ST_CMP     = 4'd4;
    localparam logic [3:0] ST_DESC_RD = 4'd5;
    localparam logic [3:0] ST_DESC_WB = 4'd6;
    localparam logic [3:0] ST_FIN_RD  = 4'd7;
    localparam logic [3:0] ST_FIN_WB  = 4'd8;
    localparam logic [3:0] ST_RESULT  = 4'd9;
    localparam logic [3:0] ST_B_RD0   = 4'd10;
    localparam logic [3:0] ST_B_RD1   = 4'd11;
    localparam logic [3:0] ST_B_WR    = 4'd12;

    localparam logic [KW-1:0] K_TOP  = KW'(LOG_LEVELS - 1);
    localparam logic [KW-1:0] K_ONE  = KW'(1);
    localparam logic [KW-1:0] K_ZERO = '0;
    localparam logic [NW-1:0] J_LAST = NW'(MAX_NODES - 1);

    function automatic logic [JAW-1:0] jaddr(input logic [KW-1:0] k,
                                             input logic [NW-1:0] n);
        return JAW'(k) * JAW'(MAX_NODES) + JAW'(n);
    endfunction

    // Node numbers on the ports wrap modulo MAX_NODES: constant lookup.
    logic [NW-1:0] wrap_lut [NIDS];
    for (genvar i = 0; i < NIDS; i++) begin : g_wrap
        assign wrap_lut[i] = NW'(i % MAX_NODES);
    end

    logic [3:0]            state_reg, state_next;
    logic [KW-1:0]         k_reg, k_next;
    logic [NW-1:0]         j_reg, j_next;
    logic [NW-1:0]         u_reg, u_next;
    logic [NW-1:0]         v_reg, v_next;
    logic [NW-1:0]         res_reg, res_next;
    logic [LOG_LEVELS-1:0] dm_reg, dm_next;
    logic                  m_valid_reg, m_valid_next;
    logic [lcab_pkg::ID_W-1:0] m_ancestor_reg, m_ancestor_next;

    logic                  jwe;
    logic [JAW-1:0]        jwaddr;
    logic [EW-1:0]         jwdata;
    logic [JAW-1:0]        jraddr_a, jraddr_b;
    logic [EW-1:0]         jrd_a, jrd_b;
    logic                  dwe;
    logic [NW-1:0]         draddr_a, draddr_b;
    logic [lcab_pkg::DEPTH_W-1:0] drd_a, drd_b;

    logic                  accept;
    logic                  out_free;
    logic [NW-1:0]         in_node, in_parent, in_u, in_v;
    logic                  a_valid, b_valid;
    logic [NW-1:0]         a_node, b_node;
    logic [lcab_pkg::DEPTH_W-1:0] ddiff;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign in_node   = wrap_lut[s_node_id];
    assign in_parent = wrap_lut[s_parent_id];
    assign in_u      = wrap_lut[s_query_u];
    assign in_v      = wrap_lut[s_query_v];
    assign a_valid   = jrd_a[NW];
    assign a_node    = jrd_a[NW-1:0];
    assign b_valid   = jrd_b[NW];
    assign b_node    = jrd_b[NW-1:0];
    assign ddiff     = (drd_a > drd_b) ? (drd_a - drd_b) : (drd_b - drd_a);

    lcab_ram #(.W(EW), .DEPTH(JD), .AW(JAW)) u_jump_ram (
        .aclk    (aclk),
        .we      (jwe),
        .waddr   (jwaddr),
        .wdata   (jwdata),
        .raddr_a (jraddr_a),
        .rdata_a (jrd_a),
        .raddr_b (jraddr_b),
        .rdata_b (jrd_b)
    );

    lcab_ram #(.W(lcab_pkg::DEPTH_W), .DEPTH(MAX_NODES), .AW(NW)) u_depth_ram (
        .aclk    (aclk),
        .we      (dwe),
        .waddr   (in_node),
        .wdata   (s_node_depth),
        .raddr_a (draddr_a),
        .rdata_a (drd_a),
        .raddr_b (draddr_b),
        .rdata_b (drd_b)
    );

    // Memory ports. Build writes level k while reading level k-1, so no read
    // ever overlaps a pending write to the same entry.
    always_comb begin
        jwe      = 1'b0;
        jwaddr   = jaddr(k_reg, j_reg);
        jwdata   = jrd_a;
        dwe      = 1'b0;
        jraddr_a = '0;
        jraddr_b = jaddr(k_reg, v_reg);
        draddr_a = in_u;
        draddr_b = in_v;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_req_type == lcab_pkg::REQ_LOAD) begin
                    jwe    = 1'b1;
                    dwe    = 1'b1;
                    jwaddr = jaddr(K_ZERO, in_node);
                    jwdata = s_is_root ? '0 : {1'b1, in_parent};
                end
            end
            ST_B_RD0:   jraddr_a = jaddr(k_reg - K_ONE, j_reg);
            ST_B_RD1: begin
                jraddr_a = jaddr(k_reg - K_ONE, a_node);
                if (!a_valid) begin
                    jwe    = 1'b1;
                    jwdata = '0;
                end
            end
            ST_B_WR:    jwe = 1'b1;
            ST_LIFT_RD: jraddr_a = jaddr(k_reg, v_reg);
            ST_DESC_RD: jraddr_a = jaddr(k_reg, u_reg);
            ST_FIN_RD:  jraddr_a = jaddr(K_ZERO, u_reg);
            default: ;
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        k_next          = k_reg;
        j_next          = j_reg;
        u_next          = u_reg;
        v_next          = v_reg;
        res_next        = res_reg;
        dm_next         = dm_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_ancestor_next = m_ancestor_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_req_type)
                        lcab_pkg::REQ_BUILD: begin
                            if (LOG_LEVELS > 1) begin
                                state_next = ST_B_RD0;
                            end
                            k_next = K_ONE;
                            j_next = '0;
                        end
                        lcab_pkg::REQ_QUERY: begin
                            state_next = ST_DEPTH;
                            u_next     = in_u;
                            v_next     = in_v;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DEPTH: begin
                // Keep the deeper node in v.
                if (drd_a > drd_b) begin
                    u_next = v_reg;
                    v_next = u_reg;
                end
                dm_next    = LOG_LEVELS'(ddiff);
                k_next     = K_TOP;
                state_next = ST_LIFT_RD;
            end
            ST_LIFT_RD: begin
                if (dm_reg[k_reg]) begin
                    state_next = ST_LIFT_WB;
                end else if (k_reg == K_ZERO) begin
                    state_next = ST_CMP;
                end else begin
                    k_next = k_reg - K_ONE;
                end
            end
            ST_LIFT_WB: begin
                if (a_valid) begin
                    v_next = a_node;
                end
                if (k_reg == K_ZERO) begin
                    state_next = ST_CMP;
                end else begin
                    k_next     = k_reg - K_ONE;
                    state_next = ST_LIFT_RD;
                end
            end
            ST_CMP: begin
                if (u_reg == v_reg) begin
                    res_next   = u_reg;
                    state_next = ST_RESULT;
                end else begin
                    k_next     = K_TOP;
                    state_next = ST_DESC_RD;
                end
            end
            ST_DESC_RD: state_next = ST_DESC_WB;
            ST_DESC_WB: begin
                if (a_valid && b_valid && a_node != b_node) begin
                    u_next = a_node;
                    v_next = b_node;
                end
                if (k_reg == K_ZERO) begin
                    state_next = ST_FIN_RD;
                end else begin
                    k_next     = k_reg - K_ONE;
                    state_next = ST_DESC_RD;
                end
            end
            ST_FIN_RD: state_next = ST_FIN_WB;
            ST_FIN_WB: begin
                res_next   = a_valid ? a_node : '0;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                // Hold until the output register is free.
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_ancestor_next = lcab_pkg::ID_W'(res_reg);
                    state_next      = ST_IDLE;
                end
            end
            ST_B_RD0: state_next = ST_B_RD1;
            ST_B_RD1: begin
                if (a_valid) begin
                    state_next = ST_B_WR;
                end else begin
                    state_next = ST_B_RD0;
                    if (j_reg == J_LAST) begin
                        j_next = '0;
                        k_next = k_reg + K_ONE;
                        if (k_reg == K_TOP) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        j_next = j_reg + NW'(1);
                    end
                end
            end
            ST_B_WR: begin
                state_next = ST_B_RD0;
                if (j_reg == J_LAST) begin
                    j_next = '0;
                    k_next = k_reg + K_ONE;
                    if (k_reg == K_TOP) begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    j_next = j_reg + NW'(1);
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg          <= k_next;
        j_reg          <= j_next;
        u_reg          <= u_next;
        v_reg          <= v_next;
        res_reg        <= res_next;
        dm_reg         <= dm_next;
        m_ancestor_reg <= m_ancestor_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_ancestor = m_ancestor_reg;

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESULT && out_free)
        |=> (m_valid && m_ancestor == lcab_pkg::ID_W'($past(res_reg))))
        else $error("finished query not moved to output register");

    a_query_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_req_type == lcab_pkg::REQ_QUERY) |=> (state_reg == ST_DEPTH))
        else $error("accepted query did not start depth read");

    a_build_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (jwe && state_reg != ST_IDLE) |-> (k_reg != K_ZERO && k_reg <= K_TOP))
        else $error("build write outside levels 1..top");

    a_desc_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LIFT_RD || state_reg == ST_DESC_RD) |-> (k_reg <= K_TOP))
        else $error("level counter out of range");

endmodule
